>>> sv/sbf_pkg.sv
package sbf_pkg;

	localparam int PIX_W      = 8;
	localparam int K_W        = 4;
	localparam int DIM_W      = 11;
	localparam int SUM_W      = 12;
	localparam int FULL_W     = 13;
	localparam int CMP_W      = 14;
	localparam int RECIP_W    = 19;
	localparam int RECIP_SH   = 18;
	localparam int PROD_W     = FULL_W + RECIP_W;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int ADDR_LSB   = 2;
	localparam int REG_IDX_W  = APB_ADDR_W - ADDR_LSB;

	localparam int DEF_MAX_KERNEL = 15;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [K_W-1:0]   KERNEL_RST = 4'd3;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

	localparam logic [REG_IDX_W-1:0] REG_KERNEL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Rounded-up 2^18 / k for the odd kernel sizes; exact floor for dividends below 2^13.
	localparam logic [RECIP_W-1:0] RECIP_TAB [16] = '{
		19'd0,      19'd262144, 19'd0, 19'd87382,
		19'd0,      19'd52429,  19'd0, 19'd37450,
		19'd0,      19'd29128,  19'd0, 19'd23832,
		19'd0,      19'd20165,  19'd0, 19'd17477
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_VSUM,
		ST_HSUM,
		ST_EMIT
	} sbf_state_t;

	typedef struct packed {
		logic [K_W-1:0]   kernel_size;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic             ok;
	} cfg_t;

	typedef struct packed {
		logic first_row;
		logic rows_full;
		logic k_one;
	} vs_ctl_t;

	typedef struct packed {
		logic win_row;
		logic win_col;
		logic col_zero;
		logic col_ge_k;
		logic row_end;
		logic frame_end;
	} item_t;

endpackage

>>> sv/sbf_in_if.sv
interface sbf_in_if;
	import sbf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

>>> sv/sbf_out_if.sv
interface sbf_out_if;
	import sbf_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             row_end;
	logic             frame_end;

	modport source (output valid, output pixel_out, output row_end, output frame_end,
		input ready);
	modport sink (input valid, input pixel_out, input row_end, input frame_end,
		output ready);
endinterface

>>> sv/sbf_cfg.sv
module sbf_cfg #(
	parameter int MAX_KERNEL = sbf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = sbf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sbf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sbf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sbf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output sbf_pkg::cfg_t                   cfg,
	output logic                            restart
);
	import sbf_pkg::*;

	logic [K_W-1:0]       kernel_q;
	logic [DIM_W-1:0]     width_q;
	logic [DIM_W-1:0]     height_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;
	logic [CMP_W-1:0]     k_ext;
	logic [CMP_W-1:0]     w_ext;
	logic [CMP_W-1:0]     h_ext;
	logic                 k_ok;
	logic                 dim_ok;

	assign idx     = paddr[APB_ADDR_W-1:ADDR_LSB];
	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr && (idx == REG_KERNEL || idx == REG_WIDTH || idx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KERNEL_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_KERNEL: kernel_q <= pwdata[K_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_KERNEL: prdata = APB_DATA_W'(kernel_q);
			REG_WIDTH:  prdata = APB_DATA_W'(width_q);
			REG_HEIGHT: prdata = APB_DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	assign k_ext  = CMP_W'(kernel_q);
	assign w_ext  = CMP_W'(width_q);
	assign h_ext  = CMP_W'(height_q);
	assign k_ok   = (kernel_q != '0) && kernel_q[0] && (k_ext <= CMP_W'(MAX_KERNEL))
		&& (k_ext <= w_ext) && (k_ext <= h_ext);
	assign dim_ok = (width_q != '0) && (w_ext <= CMP_W'(MAX_WIDTH))
		&& (height_q != '0) && (h_ext <= CMP_W'(MAX_HEIGHT));

	assign cfg.kernel_size  = kernel_q;
	assign cfg.image_width  = width_q;
	assign cfg.image_height = height_q;
	assign cfg.ok           = k_ok && dim_ok;

endmodule

>>> sv/sbf_vsum.sv
module sbf_vsum #(
	parameter int MAX_KERNEL = sbf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = sbf_pkg::DEF_MAX_WIDTH,
	localparam int COL_W       = $clog2(MAX_WIDTH),
	localparam int STORE_DEPTH = (MAX_KERNEL - 1) * MAX_WIDTH + 1,
	localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [COL_W-1:0]            col,
	input  logic [SA_W-1:0]             slot_addr,
	input  logic [sbf_pkg::PIX_W-1:0]   pixel,
	input  sbf_pkg::vs_ctl_t            ctl,
	output logic [sbf_pkg::FULL_W-1:0]  full
);
	import sbf_pkg::*;

	logic [SUM_W-1:0] col_sums [MAX_WIDTH];
	logic [PIX_W-1:0] row_store [STORE_DEPTH];

	logic             pending_s1;
	logic [COL_W-1:0] col_s1;
	logic [SA_W-1:0]  slot_s1;
	logic [PIX_W-1:0] pix_s1;
	vs_ctl_t          ctl_s1;
	logic [SUM_W-1:0] cs_rd_s1;
	logic [PIX_W-1:0] old_rd_s1;
	logic             wr_en;
	logic [SUM_W-1:0] new_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_s1 <= 1'b0;
		end else begin
			pending_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			col_s1  <= col;
			slot_s1 <= slot_addr;
			pix_s1  <= pixel;
			ctl_s1  <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cs_rd_s1 <= col_sums[col];
		end
		if (wr_en) begin
			col_sums[col_s1] <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			old_rd_s1 <= row_store[slot_addr];
		end
		if (wr_en) begin
			row_store[slot_s1] <= pix_s1;
		end
	end

	assign wr_en   = pending_s1 && !ctl_s1.k_one;
	assign full    = (ctl_s1.first_row ? '0 : FULL_W'(cs_rd_s1)) + FULL_W'(pix_s1);
	assign new_sum = ctl_s1.rows_full ? SUM_W'(full - FULL_W'(old_rd_s1)) : SUM_W'(full);

endmodule

>>> sv/sbf_div.sv
module sbf_div (
	input  logic                        clk,
	input  logic                        start,
	input  logic [sbf_pkg::FULL_W-1:0]  x,
	input  logic [sbf_pkg::K_W-1:0]     k,
	output logic [sbf_pkg::PIX_W-1:0]   q
);
	import sbf_pkg::*;

	logic [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(x) * PROD_W'(RECIP_TAB[k]);
		end
	end

	assign q = prod_s1[RECIP_SH +: PIX_W];

endmodule

>>> sv/separable_box_filter_running_sum_unit.sv
// Each item is accepted in ST_IDLE (memory read), then passes ST_VSUM (write-back, column
// mean from the shared divider), ST_HSUM (row mean, same divider) and ST_EMIT, which loads
// the output register once it is free. A full-window-row item with no result skips ST_EMIT,
// one before that row ST_HSUM too. Only ST_IDLE takes items; with invalid settings none leave it.
// Reset (arst_n, asynchronous): counters, running sum and window clear, registers take
// their defaults; the row and column memories are not cleared and need no clearing pass.
module separable_box_filter_running_sum_unit #(
	parameter int MAX_KERNEL = sbf_pkg::DEF_MAX_KERNEL,
	parameter int MAX_WIDTH  = sbf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sbf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sbf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sbf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	sbf_in_if.sink                          video,
	sbf_out_if.source                       filtered
);
	import sbf_pkg::*;

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int STORE_DEPTH = (MAX_KERNEL - 1) * MAX_WIDTH + 1;
	localparam int SA_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int KIDX_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

	cfg_t             cfg;
	logic             restart;
	sbf_state_t       state_q;
	sbf_state_t       state_d;
	logic             accept;
	logic             take;
	logic             div_start;
	logic             load_out;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [K_W-1:0]   slot_row_q;
	logic [SA_W-1:0]  base_q;
	logic [K_W-1:0]   k;
	logic [K_W-1:0]   km1;
	logic [CMP_W-1:0] col_ext;
	logic [CMP_W-1:0] row_ext;
	logic [CMP_W-1:0] km1_ext;
	logic             col_wrap;
	logic             row_wrap;
	logic             slot_wrap;
	item_t            item_d;
	item_t            item_s1;
	vs_ctl_t          vs_ctl;
	logic [SA_W-1:0]  slot_addr;
	logic [FULL_W-1:0] vs_full;

	logic [FULL_W-1:0] div_x;
	logic [PIX_W-1:0]  div_q;
	logic [SUM_W-1:0]  row_sum_q;
	logic [PIX_W-1:0]  win_q [MAX_KERNEL];
	logic [PIX_W-1:0]  tap;
	logic [FULL_W-1:0] hs_rs;

	logic              out_valid_q;
	logic [PIX_W-1:0]  pix_out_q;
	logic              row_end_q;
	logic              frame_end_q;

	sbf_cfg #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.restart(restart)
	);

	assign accept  = video.valid && video.ready;
	assign take    = out_valid_q && filtered.ready;
	assign k       = cfg.kernel_size;
	assign km1     = k - 1'b1;
	assign col_ext = CMP_W'(col_q);
	assign row_ext = CMP_W'(row_q);
	assign km1_ext = CMP_W'(km1);

	assign col_wrap  = (col_ext + 1'b1) >= CMP_W'(cfg.image_width);
	assign row_wrap  = (row_ext + 1'b1) >= CMP_W'(cfg.image_height);
	assign slot_wrap = (k == K_W'(1)) || (K_W'(slot_row_q + 1'b1) == km1);

	assign item_d.win_row   = row_ext >= km1_ext;
	assign item_d.win_col   = col_ext >= km1_ext;
	assign item_d.col_zero  = (col_q == '0);
	assign item_d.col_ge_k  = col_ext >= CMP_W'(k);
	assign item_d.row_end   = (col_ext + 1'b1) == CMP_W'(cfg.image_width);
	assign item_d.frame_end = item_d.row_end
		&& ((row_ext + 1'b1) == CMP_W'(cfg.image_height));

	assign vs_ctl.first_row = (row_q == '0) || (k == K_W'(1));
	assign vs_ctl.rows_full = item_d.win_row;
	assign vs_ctl.k_one     = (k == K_W'(1));
	assign slot_addr        = base_q + SA_W'(col_q);

	sbf_vsum #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_WIDTH (MAX_WIDTH)
	) u_vsum (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && cfg.ok),
		.col      (col_q),
		.slot_addr(slot_addr),
		.pixel    (video.pixel_in),
		.ctl      (vs_ctl),
		.full     (vs_full)
	);

	assign div_x = (state_q == ST_VSUM) ? vs_full : hs_rs;

	sbf_div u_div (
		.clk  (clk),
		.start(div_start),
		.x    (div_x),
		.k    (k),
		.q    (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			slot_row_q <= '0;
			base_q     <= '0;
		end else if (restart) begin
			col_q      <= '0;
			row_q      <= '0;
			slot_row_q <= '0;
			base_q     <= '0;
		end else if (accept && cfg.ok) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q      <= '0;
					slot_row_q <= '0;
					base_q     <= '0;
				end else begin
					row_q <= ROW_W'(row_q + 1'b1);
					if (slot_wrap) begin
						slot_row_q <= '0;
						base_q     <= '0;
					end else begin
						slot_row_q <= K_W'(slot_row_q + 1'b1);
						base_q     <= SA_W'(base_q + SA_W'(MAX_WIDTH));
					end
				end
			end else begin
				col_q <= COL_W'(col_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && cfg.ok) state_d = ST_VSUM;
			ST_VSUM: state_d = item_s1.win_row ? ST_HSUM : ST_IDLE;
			ST_HSUM: state_d = item_s1.win_col ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		video.ready = 1'b0;
		div_start   = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: video.ready = 1'b1;
			ST_VSUM: div_start = 1'b1;
			ST_HSUM: div_start = 1'b1;
			ST_EMIT: load_out = !out_valid_q || filtered.ready;
			default: ;
		endcase
	end

	assign tap   = win_q[KIDX_W'(km1)];
	assign hs_rs = (item_s1.col_zero ? '0 : FULL_W'(row_sum_q)) + FULL_W'(div_q)
		- (item_s1.col_ge_k ? FULL_W'(tap) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q <= '0;
		end else if (restart) begin
			row_sum_q <= '0;
		end else if (state_q == ST_HSUM) begin
			row_sum_q <= SUM_W'(hs_rs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_KERNEL; i++) begin
				win_q[i] <= '0;
			end
		end else if (state_q == ST_HSUM) begin
			win_q[0] <= div_q;
			for (int i = 1; i < MAX_KERNEL; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pix_out_q   <= div_q;
			row_end_q   <= item_s1.row_end;
			frame_end_q <= item_s1.frame_end;
		end
	end

	assign filtered.valid     = out_valid_q;
	assign filtered.pixel_out = pix_out_q;
	assign filtered.row_end   = row_end_q;
	assign filtered.frame_end = frame_end_q;

endmodule

>>> sv/sbf_chk.sv
module sbf_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sbf_pkg::PIX_W-1:0]  pixel_out,
	input logic                       row_end,
	input logic                       frame_end
);
	import sbf_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_out) && $stable(row_end)
			&& $stable(frame_end))
		else $error("stalled result item changed");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame end without row end");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("result item without a matching input item");

endmodule

bind separable_box_filter_running_sum_unit sbf_chk u_sbf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (video.valid),
	.in_ready (video.ready),
	.out_valid(filtered.valid),
	.out_ready(filtered.ready),
	.pixel_out(filtered.pixel_out),
	.row_end  (filtered.row_end),
	.frame_end(filtered.frame_end)
);

>>> tb/sv/tb.sv
module tb;
	import sbf_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int STORE_DEPTH   = (DEF_MAX_KERNEL - 1) * DEF_MAX_WIDTH + 1;
	localparam int IDLE_PERCENT  = 6;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 60;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             row_end;
		logic             frame_end;
	} filtered_pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sbf_in_if  video_if ();
	sbf_out_if filt_if ();

	separable_box_filter_running_sum_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.video    (video_if),
		.filtered (filt_if)
	);

	logic [PIX_W-1:0] pending_pixels [$];
	filtered_pixel_t  expected_pixels [$];
	int               mismatch_count;
	int               cycle_count;
	bit               steady;
	bit               hold_armed;
	int               hold_left;
	bit               offer_taken;

	// Filter state mirrored from the block.
	logic [K_W-1:0]   cfg_k;
	logic [DIM_W-1:0] cfg_w;
	logic [DIM_W-1:0] cfg_h;
	logic [PIX_W-1:0] row_hist [STORE_DEPTH];
	logic [SUM_W-1:0] col_sum [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] mean_win [DEF_MAX_KERNEL];
	int unsigned      hsum;
	int unsigned      col_pos;
	int unsigned      row_pos;

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit geometry_valid();
		if (cfg_k == 0 || cfg_k[0] == 1'b0 || cfg_k > DEF_MAX_KERNEL) return 1'b0;
		if (cfg_w == 0 || cfg_w > DEF_MAX_WIDTH) return 1'b0;
		if (cfg_h == 0 || cfg_h > DEF_MAX_HEIGHT) return 1'b0;
		if (cfg_k > cfg_w || cfg_k > cfg_h) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
		input logic [APB_DATA_W-1:0] value);
		case (idx)
			REG_KERNEL: cfg_k = value[K_W-1:0];
			REG_WIDTH:  cfg_w = value[DIM_W-1:0];
			REG_HEIGHT: cfg_h = value[DIM_W-1:0];
			default:    return;
		endcase
		col_pos = 0;
		row_pos = 0;
		hsum = 0;
	endfunction

	// Vertical running sum per column, then a horizontal running sum of the column means.
	function automatic void box_filter_step(input logic [PIX_W-1:0] p);
		int unsigned     k, c, r, full, prior, slot, cm, rs, wi;
		filtered_pixel_t res;
		if (!geometry_valid()) return;
		k = cfg_k;
		c = col_pos;
		r = row_pos;
		if (k == 1) begin
			full = p;
		end else begin
			prior = (r == 0) ? 0 : col_sum[c];
			full = prior + p;
			slot = (r % (k - 1)) * DEF_MAX_WIDTH + c;
			if (r >= k - 1) begin
				col_sum[c] = SUM_W'(full - row_hist[slot]);
			end else begin
				col_sum[c] = SUM_W'(full);
			end
			row_hist[slot] = p;
		end
		if (r >= k - 1) begin
			wi = c % k;
			cm = full / k;
			rs = (c == 0) ? cm : hsum + cm;
			if (c >= k) rs -= mean_win[wi];
			mean_win[wi] = PIX_W'(cm);
			hsum = rs & 32'hFFF;
			if (c >= k - 1) begin
				res.pixel = PIX_W'(rs / k);
				res.row_end = (c == cfg_w - 1);
				res.frame_end = (c == cfg_w - 1) && (r == cfg_h - 1);
				expected_pixels.push_back(res);
			end
		end
		if (c + 1 >= cfg_w) begin
			col_pos = 0;
			row_pos = (r + 1 >= cfg_h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && video_if.valid && video_if.ready) begin
			box_filter_step(video_if.pixel_in);
			void'(pending_pixels.pop_front());
			offer_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(video_if.valid && !offer_taken)) begin
			offer_taken = 1'b0;
			if (pending_pixels.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
				video_if.valid <= 1'b1;
				video_if.pixel_in <= pending_pixels[0];
			end else begin
				video_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				filt_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_armed && filt_if.valid) begin
				hold_armed = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				filt_if.ready <= 1'b0;
			end else begin
				filt_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
			end
		end
	end

	always @(posedge clk) begin : check_output
		filtered_pixel_t want;
		if (arst_n && filt_if.valid && filt_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel_out: no item expected, actual %0d", filt_if.pixel_out);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (filt_if.pixel_out !== want.pixel) begin
					$error("pixel_out: expected %0d, actual %0d", want.pixel, filt_if.pixel_out);
					mismatch_count++;
				end
				if (filt_if.row_end !== want.row_end) begin
					$error("row_end: expected %0d, actual %0d", want.row_end, filt_if.row_end);
					mismatch_count++;
				end
				if (filt_if.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d", want.frame_end,
						filt_if.frame_end);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_pixels.size() > 0 || video_if.valid || expected_pixels.size() > 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {ADDR_LSB{1'b0}}};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		apply_register(idx, APB_DATA_W'(value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic [REG_IDX_W-1:0] idx, input int want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, {ADDR_LSB{1'b0}}};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(want)) begin
			$error("prdata: expected %0d, actual %0d", want, prdata);
			mismatch_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int k, input int w, input int h);
		wait_idle();
		reg_write(REG_KERNEL, k);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	task automatic queue_random(input int n);
		repeat (n) pending_pixels.push_back(PIX_W'($urandom_range(0, 255)));
	endtask

	task automatic queue_level(input int n, input logic [PIX_W-1:0] level);
		repeat (n) pending_pixels.push_back(level);
	endtask

	initial begin
		int k, w, h, n, random_items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		video_if.valid = 1'b0;
		video_if.pixel_in = '0;
		filt_if.ready = 1'b0;
		cfg_k = KERNEL_RST;
		cfg_w = WIDTH_RST;
		cfg_h = HEIGHT_RST;
		foreach (row_hist[i]) row_hist[i] = '0;
		foreach (col_sum[i]) col_sum[i] = '0;
		foreach (mean_win[i]) mean_win[i] = '0;
		hsum = 0;
		col_pos = 0;
		row_pos = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		reg_check(REG_KERNEL, KERNEL_RST);
		reg_check(REG_WIDTH, WIDTH_RST);
		reg_check(REG_HEIGHT, HEIGHT_RST);

		// Saturated and black frames back to back, so the second frame wraps the counters.
		configure(3, 4, 3);
		queue_level(12, 8'hFF);
		queue_level(12, 8'h00);

		// A write outside the register map must leave the frame position alone.
		configure(3, 3, 3);
		queue_random(4);
		wait_idle();
		reg_write(REG_SPARE, 5);
		queue_random(5);

		// Rewriting the same kernel size still restarts the frame.
		queue_random(4);
		wait_idle();
		reg_write(REG_KERNEL, 3);
		queue_random(9);

		// Settings that must swallow every item without a result.
		configure(0, 5, 5);
		queue_random(2);
		configure(2, 5, 5);
		queue_random(2);
		configure(14, 20, 20);
		queue_random(2);
		configure(7, 6, 9);
		queue_random(2);
		configure(7, 9, 6);
		queue_random(2);
		configure(3, 0, 5);
		queue_random(2);
		configure(3, 1025, 5);
		queue_random(2);
		configure(3, 2047, 5);
		queue_random(2);
		configure(3, 5, 0);
		queue_random(2);
		configure(3, 5, 1025);
		queue_random(2);
		configure(3, 5, 2047);
		queue_random(2);

		// A kernel of one passes every item straight through.
		configure(1, 1, 1);
		queue_level(1, 8'hFF);
		queue_level(1, 8'h00);
		queue_random(3);

		configure(1, 1024, 1);
		steady = 1'b1;
		queue_random(16);

		configure(1, 1, 1024);
		queue_random(16);

		configure(15, 15, 15);
		queue_level(225, 8'hFF);
		wait_idle();
		steady = 1'b0;

		hold_armed = 1'b1;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: configure(2 * $urandom_range(0, 7), $urandom_range(1, 20),
						$urandom_range(1, 20));
					1: begin
						k = 2 * $urandom_range(1, 7) + 1;
						configure(k, $urandom_range(1, k - 1), $urandom_range(k, 20));
					end
					default: begin
						k = 2 * $urandom_range(1, 7) + 1;
						configure(k, $urandom_range(k, 20), $urandom_range(1, k - 1));
					end
				endcase
				queue_random($urandom_range(1, 4));
			end else begin
				k = 2 * $urandom_range(0, 3) + 1;
				w = $urandom_range(k, k + 4);
				h = $urandom_range(k, k + 2);
				configure(k, w, h);
				n = w * h + $urandom_range(0, w - 1);
				queue_random(n);
				random_items += n;
			end
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
